// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the convolution engine core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define C1DRE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("c1dre assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define C1DRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("c1dre assertion failed");

`endif

// ===== rtl/core/c1dre_pkg.sv =====
// Package with the constants, types and helpers of the convolution engine.
package c1dre_pkg;

   localparam int KernelMaxDefault   = 4;
   localparam int ChannelsMaxDefault = 16;
   localparam int FiltersMaxDefault  = 32;
   localparam int FracBitsDefault    = 8;

   localparam int ReqDataWidth = 32;
   localparam int ReqUserWidth = 2;
   localparam int RspDataWidth = 32;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 6;

   localparam int SampleWidth = 16;
   localparam int ProdWidth   = 32;
   localparam int AccWidth    = 40;
   localparam int EntryWidth  = 11;
   localparam int OutValueWidth  = 15;
   localparam int OutFilterWidth = 5;
   localparam int OutFrameWidth  = 8;
   localparam int FramesWidth    = 9;

   localparam logic [4:0] InChannelsReset  = 5'd16;
   localparam logic [5:0] FilterCountReset = 6'd32;
   localparam logic [2:0] KernelLenReset   = 3'd3;

   typedef enum logic [1:0] {
      ACT_LOAD_WEIGHT = 2'd0,
      ACT_LOAD_BIAS   = 2'd1,
      ACT_SAMPLE      = 2'd2,
      ACT_RESTART     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CSR_IN_CHANNELS  = 2'd0,
      CSR_FILTER_COUNT = 2'd1,
      CSR_KERNEL_LEN   = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_MAC   = 4'b0010,
      S_DRAIN = 4'b0100,
      S_OUT   = 4'b1000
   } seq_state_type;

   function automatic int addr_width(int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

// ===== rtl/core/conv1d_relu_engine_core.sv =====
// Top level of the one-dimensional convolution engine with ReLU output.
// Loads, restarts and samples that do not complete an emitting frame leave the sequencer idle.
// A frame-completing sample runs one multiply-accumulate unit over the weight and window
// memories, channels*kernel products per filter, then drains it and emits that filter's word;
// the input is ready again once the last word of the frame is registered, later if a result
// word is held back. Reset clears the control state only.
`include "assert_macros.svh"

module conv1d_relu_engine_core #(
   parameter int KERNEL_MAX   = c1dre_pkg::KernelMaxDefault,
   parameter int CHANNELS_MAX = c1dre_pkg::ChannelsMaxDefault,
   parameter int FILTERS_MAX  = c1dre_pkg::FiltersMaxDefault,
   parameter int FRAC_BITS    = c1dre_pkg::FracBitsDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // entry_index [10:0], data_value [26:11], zero padding above.
   input  logic [c1dre_pkg::ReqDataWidth-1:0]   req_tdata,
   // action [1:0].
   input  logic [c1dre_pkg::ReqUserWidth-1:0]   req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out_value [14:0], filter_index [19:15], frame_index [27:20], zero padding above.
   output logic [c1dre_pkg::RspDataWidth-1:0]   rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [c1dre_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [c1dre_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import c1dre_pkg::*;

   localparam int WeightDepth = KERNEL_MAX * CHANNELS_MAX * FILTERS_MAX;
   localparam int WinDepth    = KERNEL_MAX * CHANNELS_MAX;
   localparam int WAW   = addr_width(WeightDepth);
   localparam int WinAW = addr_width(WinDepth);
   localparam int FW    = addr_width(FILTERS_MAX);
   localparam int KW    = addr_width(KERNEL_MAX);
   localparam int CW    = addr_width(CHANNELS_MAX);
   localparam int KCW   = $clog2(KERNEL_MAX + 1);
   localparam int CCW   = $clog2(CHANNELS_MAX + 1);
   localparam int FCW   = $clog2(FILTERS_MAX + 1);
   localparam int SW    = KCW + 1;
   localparam logic signed [AccWidth:0] RoundHalf = (41'sd1 <<< FRAC_BITS) >>> 1;

   // Configuration and sequence state.
   logic [4:0] in_channels_ff, in_channels_in;
   logic [5:0] filter_count_ff, filter_count_in;
   logic [2:0] kernel_len_ff, kernel_len_in;
   logic [CW-1:0] ch_cnt_ff, ch_cnt_in;
   logic [FramesWidth-1:0] frames_ff, frames_in;
   logic [KW-1:0] head_ff, head_in;

   // Sequencer.
   seq_state_type state_ff, state_in;
   logic [FW-1:0]  f_ff, f_in;
   logic [CW-1:0]  c_ff, c_in;
   logic [KW-1:0]  k_ff, k_in;
   logic [KW-1:0]  slot_ff, slot_in;
   logic [KW-1:0]  start_slot_ff, start_slot_in;
   logic [WAW-1:0] wa_ff, wa_in;
   logic [OutFrameWidth-1:0] frame_idx_ff, frame_idx_in;

   // Multiply-accumulate pipeline.
   logic p1_ff, p1_first_ff, p1_last_ff, p2_ff, p2_last_ff;
   logic signed [ProdWidth-1:0] prod_ff, prod_in;
   logic signed [AccWidth-1:0]  acc_ff, acc_in;

   // Result word register.
   logic rsp_valid_ff, rsp_valid_in;
   logic [OutValueWidth-1:0]  rsp_value_ff, rsp_value_in;
   logic [OutFilterWidth-1:0] rsp_filter_ff, rsp_filter_in;
   logic [OutFrameWidth-1:0]  rsp_frame_ff, rsp_frame_in;
   logic rsp_last_ff, rsp_last_in;

   logic [CCW-1:0] nc;
   logic [FCW-1:0] nf;
   logic [KCW-1:0] nk;

   action_type req_action;
   logic [EntryWidth-1:0]  entry_idx;
   logic [SampleWidth-1:0] data_val;
   logic accept;

   logic [SampleWidth-1:0] weight_rdata, bias_rdata, win_rdata;
   logic weight_we, bias_we, win_we;
   logic [WinAW-1:0] win_waddr, win_raddr;

   logic frame_done, emit, mac_first, mac_last, c_end, f_last, out_free;
   logic [FramesWidth-1:0] frames_inc, frames_diff;
   logic [KW-1:0] head_step, slot_step, start_slot;
   logic [SW-1:0] start_tmp;
   logic [OutFrameWidth-1:0] fi_calc;
   logic signed [AccWidth:0] rnd, quo;
   logic [OutValueWidth-1:0] relu_value;

   assign nc = CCW'((in_channels_ff == 5'd0) ? 1 :
                    ((32'(in_channels_ff) > CHANNELS_MAX) ? CHANNELS_MAX
                                                          : 32'(in_channels_ff)));
   assign nf = FCW'((filter_count_ff == 6'd0) ? 1 :
                    ((32'(filter_count_ff) > FILTERS_MAX) ? FILTERS_MAX
                                                          : 32'(filter_count_ff)));
   assign nk = KCW'((kernel_len_ff == 3'd0) ? 1 :
                    ((32'(kernel_len_ff) > KERNEL_MAX) ? KERNEL_MAX
                                                       : 32'(kernel_len_ff)));

   assign req_action = action_type'(req_tuser[1:0]);
   assign entry_idx  = req_tdata[10:0];
   assign data_val   = req_tdata[26:11];
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign weight_we = accept && (req_action == ACT_LOAD_WEIGHT)
                      && (32'(entry_idx) < WeightDepth);
   assign bias_we   = accept && (req_action == ACT_LOAD_BIAS)
                      && (32'(entry_idx) < FILTERS_MAX);
   assign win_we    = accept && (req_action == ACT_SAMPLE);
   assign win_waddr = WinAW'(head_ff) * WinAW'(CHANNELS_MAX) + WinAW'(ch_cnt_ff);
   assign win_raddr = WinAW'(slot_ff) * WinAW'(CHANNELS_MAX) + WinAW'(c_ff);

   c1dre_ram #(.WIDTH(SampleWidth), .DEPTH(WeightDepth)) u_weight_ram (
      .clock   (clock),
      .wr_en   (weight_we),
      .wr_addr (WAW'(entry_idx)),
      .wr_data (data_val),
      .rd_addr (wa_ff),
      .rd_data (weight_rdata)
   );

   c1dre_ram #(.WIDTH(SampleWidth), .DEPTH(FILTERS_MAX)) u_bias_ram (
      .clock   (clock),
      .wr_en   (bias_we),
      .wr_addr (FW'(entry_idx)),
      .wr_data (data_val),
      .rd_addr (f_ff),
      .rd_data (bias_rdata)
   );

   c1dre_ram #(.WIDTH(SampleWidth), .DEPTH(WinDepth)) u_window_ram (
      .clock   (clock),
      .wr_en   (win_we),
      .wr_addr (win_waddr),
      .wr_data (data_val),
      .rd_addr (win_raddr),
      .rd_data (win_rdata)
   );

   // Frame bookkeeping for an arriving sample.
   assign frame_done  = (CCW'(ch_cnt_ff) + CCW'(1)) == nc;
   assign frames_inc  = (frames_ff == 9'd511) ? frames_ff : frames_ff + 9'd1;
   assign emit        = frames_inc >= 9'(nk);
   assign frames_diff = frames_inc - 9'(nk);
   assign fi_calc     = (frames_diff > 9'd255) ? 8'd255 : frames_diff[7:0];
   assign head_step   = ((KCW'(head_ff) + KCW'(1)) == KCW'(KERNEL_MAX)) ? '0
                                                                         : head_ff + KW'(1);
   assign start_tmp   = SW'(head_ff) + SW'(KERNEL_MAX) + SW'(1) - SW'(nk);
   assign start_slot  = (start_tmp >= SW'(KERNEL_MAX)) ? KW'(start_tmp - SW'(KERNEL_MAX))
                                                       : KW'(start_tmp);

   // Sequencer stepping.
   assign c_end     = (CCW'(c_ff) + CCW'(1)) == nc;
   assign mac_last  = c_end && ((KCW'(k_ff) + KCW'(1)) == nk);
   assign mac_first = (c_ff == '0) && (k_ff == '0);
   assign slot_step = ((KCW'(slot_ff) + KCW'(1)) == KCW'(KERNEL_MAX)) ? '0
                                                                      : slot_ff + KW'(1);
   assign f_last    = (FCW'(f_ff) + FCW'(1)) == nf;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Rounding, saturation and ReLU of the finished sum.
   assign rnd = 41'(acc_ff) + RoundHalf;
   assign quo = rnd >>> FRAC_BITS;
   assign relu_value = (rnd <= 41'sd0) ? '0 :
                       ((quo > 41'sd32767) ? 15'h7FFF : quo[14:0]);

   assign prod_in = $signed(weight_rdata) * $signed(win_rdata);

   always_comb begin
      acc_in = acc_ff;
      priority if (p2_ff) begin
         acc_in = acc_ff + 40'(prod_ff);
      end else if (p1_ff && p1_first_ff) begin
         acc_in = 40'($signed(bias_rdata)) <<< FRAC_BITS;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_comb begin
      in_channels_in  = in_channels_ff;
      filter_count_in = filter_count_ff;
      kernel_len_in   = kernel_len_ff;
      ch_cnt_in       = ch_cnt_ff;
      frames_in       = frames_ff;
      head_in         = head_ff;
      state_in        = state_ff;
      f_in            = f_ff;
      c_in            = c_ff;
      k_in            = k_ff;
      slot_in         = slot_ff;
      start_slot_in   = start_slot_ff;
      wa_in           = wa_ff;
      frame_idx_in    = frame_idx_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_value_in    = rsp_value_ff;
      rsp_filter_in   = rsp_filter_ff;
      rsp_frame_in    = rsp_frame_ff;
      rsp_last_in     = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_LOAD_WEIGHT, ACT_LOAD_BIAS: begin
                  end
                  ACT_SAMPLE: begin
                     if (!frame_done) begin
                        ch_cnt_in = ch_cnt_ff + CW'(1);
                     end else begin
                        ch_cnt_in = '0;
                        frames_in = frames_inc;
                        head_in   = head_step;
                        if (emit) begin
                           state_in      = S_MAC;
                           frame_idx_in  = fi_calc;
                           start_slot_in = start_slot;
                           slot_in       = start_slot;
                           f_in          = '0;
                           c_in          = '0;
                           k_in          = '0;
                           wa_in         = '0;
                        end
                     end
                  end
                  ACT_RESTART: begin
                     ch_cnt_in = '0;
                     frames_in = '0;
                     head_in   = '0;
                  end
               endcase
            end
         end
         S_MAC: begin
            wa_in = wa_ff + WAW'(nf);
            if (mac_last) begin
               state_in = S_DRAIN;
            end else if (c_end) begin
               c_in    = '0;
               k_in    = k_ff + KW'(1);
               slot_in = slot_step;
            end else begin
               c_in = c_ff + CW'(1);
            end
         end
         S_DRAIN: begin
            if (p2_ff && p2_last_ff) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = relu_value;
               rsp_filter_in = OutFilterWidth'(f_ff);
               rsp_frame_in  = frame_idx_ff;
               rsp_last_in   = f_last;
               if (f_last) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_MAC;
                  f_in     = f_ff + FW'(1);
                  wa_in    = WAW'(f_ff) + WAW'(1);
                  c_in     = '0;
                  k_in     = '0;
                  slot_in  = start_slot_ff;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A write to one of the three configuration registers takes effect and restarts the sequence.
      if (csr_we) begin
         if (csr_index == CSR_IN_CHANNELS) begin
            in_channels_in = csr_wdata[4:0];
         end
         if (csr_index == CSR_FILTER_COUNT) begin
            filter_count_in = csr_wdata[5:0];
         end
         if (csr_index == CSR_KERNEL_LEN) begin
            kernel_len_in = csr_wdata[2:0];
         end
         if (csr_index == CSR_IN_CHANNELS || csr_index == CSR_FILTER_COUNT
             || csr_index == CSR_KERNEL_LEN) begin
            ch_cnt_in = '0;
            frames_in = '0;
            head_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_channels_ff  <= InChannelsReset;
         filter_count_ff <= FilterCountReset;
         kernel_len_ff   <= KernelLenReset;
         ch_cnt_ff       <= '0;
         frames_ff       <= '0;
         head_ff         <= '0;
         state_ff        <= S_IDLE;
         f_ff            <= '0;
         c_ff            <= '0;
         k_ff            <= '0;
         slot_ff         <= '0;
         start_slot_ff   <= '0;
         wa_ff           <= '0;
         p1_ff           <= 1'b0;
         p2_ff           <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         in_channels_ff  <= in_channels_in;
         filter_count_ff <= filter_count_in;
         kernel_len_ff   <= kernel_len_in;
         ch_cnt_ff       <= ch_cnt_in;
         frames_ff       <= frames_in;
         head_ff         <= head_in;
         state_ff        <= state_in;
         f_ff            <= f_in;
         c_ff            <= c_in;
         k_ff            <= k_in;
         slot_ff         <= slot_in;
         start_slot_ff   <= start_slot_in;
         wa_ff           <= wa_in;
         p1_ff           <= (state_ff == S_MAC);
         p2_ff           <= p1_ff;
         rsp_valid_ff    <= rsp_valid_in;
      end
      frame_idx_ff  <= frame_idx_in;
      p1_first_ff   <= mac_first;
      p1_last_ff    <= mac_last;
      p2_last_ff    <= p1_last_ff;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_filter_ff <= rsp_filter_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_frame_ff, rsp_filter_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;

   `C1DRE_ASSERT_SAME(a_counters_in_range, clock, reset, state_ff == S_MAC, (KCW'(k_ff) < nk) && (CCW'(c_ff) < nc))
   `C1DRE_ASSERT_SAME(a_bias_not_on_product, clock, reset, p2_ff, !(p1_ff && p1_first_ff))
   `C1DRE_ASSERT_SAME(a_idle_pipe_empty, clock, reset, state_ff == S_IDLE, !p1_ff && !p2_ff)
   `C1DRE_ASSERT_NEXT(a_last_product_to_out, clock, reset, p2_ff && p2_last_ff, state_ff == S_OUT)

endmodule

// ===== rtl/core/c1dre_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module c1dre_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [c1dre_pkg::addr_width(DEPTH)-1:0]    wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [c1dre_pkg::addr_width(DEPTH)-1:0]    rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);
   import c1dre_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/sv/c1dre_output_checker.sv =====
// Checker for the convolution engine: predicts each output word from the observed words and compares.
module c1dre_output_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [c1dre_pkg::ReqDataWidth-1:0]   req_tdata,
   input  logic [c1dre_pkg::ReqUserWidth-1:0]   req_tuser,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [c1dre_pkg::RspDataWidth-1:0]   rsp_tdata,
   input  logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [c1dre_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [c1dre_pkg::CsrDataWidth-1:0]   csr_wdata,
   output int                                   mismatches,
   output int                                   outstanding
);
   import c1dre_pkg::*;

   localparam int KernelSlots  = KernelMaxDefault;
   localparam int ChannelSlots = ChannelsMaxDefault;
   localparam int FilterSlots  = FiltersMaxDefault;
   localparam int FracBits     = FracBitsDefault;
   localparam int WeightDepth  = KernelSlots * ChannelSlots * FilterSlots;
   localparam int WindowDepth  = KernelSlots * ChannelSlots;
   localparam int FramesLimit  = 511;
   localparam int FrameIndexLimit = 255;
   localparam longint OutLimit = 32767;
   localparam int ReportLimit  = 40;

   typedef struct packed {
      logic [OutValueWidth-1:0]  value;
      logic [OutFilterWidth-1:0] filter;
      logic [OutFrameWidth-1:0]  frame;
      logic                      last;
   } relu_word_type;

   logic signed [SampleWidth-1:0] weight_mem [WeightDepth];
   logic signed [SampleWidth-1:0] bias_mem [FilterSlots];
   logic signed [SampleWidth-1:0] window_mem [WindowDepth];
   logic [4:0] channels_reg;
   logic [5:0] filters_reg;
   logic [2:0] kernel_reg;
   int unsigned chan_pos;
   int unsigned frames_done;
   int unsigned head_slot;
   relu_word_type queued_outputs [$];

   task automatic report_mismatch(string what, longint got, longint want);
      mismatches++;
      if (mismatches <= ReportLimit) begin
         $display("c1dre check at %0t: %s: got %0d, expected %0d", $time, what, got, want);
      end
   endtask

   function automatic int unsigned clamp_setting(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void restart_sequence();
      chan_pos = 0;
      frames_done = 0;
      head_slot = 0;
   endfunction

   // Bias plus the windowed sum, rounded half up, saturated and clamped at zero.
   function automatic logic [OutValueWidth-1:0] relu_output(int unsigned newest, int unsigned f,
         int unsigned nc, int unsigned nf, int unsigned nk);
      logic signed [AccWidth-1:0] acc;
      logic signed [ProdWidth-1:0] prod;
      logic signed [SampleWidth-1:0] w;
      longint rounded;
      int unsigned slot;
      int unsigned addr;
      acc = bias_mem[f];
      acc = acc <<< FracBits;
      for (int unsigned k = 0; k < nk; k++) begin
         slot = (newest + KernelSlots - (nk - 1) + k) % KernelSlots;
         for (int unsigned c = 0; c < nc; c++) begin
            addr = (k * nc + c) * nf + f;
            w = (addr < WeightDepth) ? weight_mem[addr] : '0;
            prod = w * window_mem[slot * ChannelSlots + c];
            acc = acc + prod;
         end
      end
      rounded = longint'(acc) + (longint'(1) <<< (FracBits - 1));
      if (rounded <= 0) return '0;
      rounded = rounded >>> FracBits;
      if (rounded > OutLimit) rounded = OutLimit;
      return rounded[OutValueWidth-1:0];
   endfunction

   task automatic apply_register(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
      case (csr_index_type'(idx))
         CSR_IN_CHANNELS: begin
            channels_reg = data[4:0];
            restart_sequence();
         end
         CSR_FILTER_COUNT: begin
            filters_reg = data[5:0];
            restart_sequence();
         end
         CSR_KERNEL_LEN: begin
            kernel_reg = data[2:0];
            restart_sequence();
         end
         default: ;
      endcase
   endtask

   task automatic take_request(action_type act, logic [EntryWidth-1:0] idx,
         logic signed [SampleWidth-1:0] val);
      int unsigned nc;
      int unsigned nf;
      int unsigned nk;
      int unsigned slot;
      int unsigned ch;
      int unsigned frame_no;
      relu_word_type word;
      nc = clamp_setting(channels_reg, ChannelSlots);
      nf = clamp_setting(filters_reg, FilterSlots);
      nk = clamp_setting(kernel_reg, KernelSlots);
      case (act)
         ACT_LOAD_WEIGHT: begin
            if (int'(idx) < WeightDepth) weight_mem[idx] = val;
         end
         ACT_LOAD_BIAS: begin
            if (int'(idx) < FilterSlots) bias_mem[idx] = val;
         end
         ACT_RESTART: restart_sequence();
         ACT_SAMPLE: begin
            slot = head_slot % KernelSlots;
            ch = chan_pos % ChannelSlots;
            window_mem[slot * ChannelSlots + ch] = val;
            if (ch + 1 < nc) begin
               chan_pos = ch + 1;
            end else begin
               chan_pos = 0;
               if (frames_done < FramesLimit) frames_done++;
               head_slot = (slot + 1) % KernelSlots;
               if (frames_done >= nk) begin
                  frame_no = frames_done - nk;
                  if (frame_no > FrameIndexLimit) frame_no = FrameIndexLimit;
                  for (int unsigned f = 0; f < nf; f++) begin
                     word.value = relu_output(slot, f, nc, nf, nk);
                     word.filter = OutFilterWidth'(f);
                     word.frame = OutFrameWidth'(frame_no);
                     word.last = (f + 1 == nf);
                     queued_outputs.push_back(word);
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic compare_word();
      relu_word_type want;
      if (queued_outputs.size() == 0) begin
         report_mismatch("output word with none expected, data", rsp_tdata, 0);
      end else begin
         want = queued_outputs.pop_front();
         if (rsp_tdata[OutValueWidth-1:0] != want.value) begin
            report_mismatch("out_value", rsp_tdata[OutValueWidth-1:0], want.value);
         end
         if (rsp_tdata[OutValueWidth +: OutFilterWidth] != want.filter) begin
            report_mismatch("filter_index", rsp_tdata[OutValueWidth +: OutFilterWidth],
               want.filter);
         end
         if (rsp_tdata[OutValueWidth + OutFilterWidth +: OutFrameWidth] != want.frame) begin
            report_mismatch("frame_index",
               rsp_tdata[OutValueWidth + OutFilterWidth +: OutFrameWidth], want.frame);
         end
         if (rsp_tlast != want.last) begin
            report_mismatch("last_of_frame", rsp_tlast, want.last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         channels_reg = InChannelsReset;
         filters_reg = FilterCountReset;
         kernel_reg = KernelLenReset;
         restart_sequence();
         queued_outputs.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) compare_word();
         if (csr_we) apply_register(csr_index, csr_wdata);
         if (req_tvalid && req_tready) begin
            take_request(action_type'(req_tuser), req_tdata[EntryWidth-1:0],
               req_tdata[EntryWidth +: SampleWidth]);
         end
      end
      outstanding <= queued_outputs.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the convolution engine: stimulus, handshake pressure and the verdict.
module tb;
   import c1dre_pkg::*;

   localparam int CLOCK_HALF = 2;
   localparam int RESET_CYCLES = 10;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 600;
   localparam longint LIMIT_CYCLES = 8_000_000;
   localparam int WEIGHT_ENTRIES = 128;
   localparam int BIAS_ENTRIES = FiltersMaxDefault;
   localparam logic [CsrIndexWidth-1:0] CSR_SPARE_INDEX = 2'd3;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [ReqDataWidth-1:0] req_tdata;
   logic [ReqUserWidth-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0] csr_wdata;
   int failures;
   int outstanding;
   bit sender_gaps = 1'b1;
   bit receiver_gaps = 1'b1;
   int receiver_hold = 0;

   always #(CLOCK_HALF) clock = ~clock;

   conv1d_relu_engine_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   c1dre_output_checker out_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (failures),
      .outstanding (outstanding)
   );

   function automatic logic [SampleWidth-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return SampleWidth'($urandom);
         1: return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
         default: return SampleWidth'(int'($urandom_range(0, 1200)) - 600);
      endcase
   endfunction

   task automatic send_word(action_type act, logic [EntryWidth-1:0] idx,
         logic [SampleWidth-1:0] val);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {{(ReqDataWidth - EntryWidth - SampleWidth){1'b0}}, val, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_sample(logic [SampleWidth-1:0] val);
      send_word(ACT_SAMPLE, EntryWidth'($urandom), val);
   endtask

   task automatic random_word(int noise_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll >= noise_pct) begin
         send_sample(pick_value());
      end else begin
         case ($urandom_range(0, 2))
            0: send_word(ACT_LOAD_WEIGHT, EntryWidth'($urandom), pick_value());
            1: send_word(ACT_LOAD_BIAS, ($urandom_range(0, 3) == 0) ? EntryWidth'($urandom)
                  : EntryWidth'($urandom_range(0, BIAS_ENTRIES - 1)), pick_value());
            default: send_word(ACT_RESTART, EntryWidth'($urandom), SampleWidth'($urandom));
         endcase
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic configure(logic [CsrDataWidth-1:0] channels, logic [CsrDataWidth-1:0] filters,
         logic [CsrDataWidth-1:0] kernel);
      wait_drained();
      write_reg(CSR_IN_CHANNELS, channels);
      write_reg(CSR_FILTER_COUNT, filters);
      write_reg(CSR_KERNEL_LEN, kernel);
      write_reg(CSR_SPARE_INDEX, CsrDataWidth'($urandom));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(logic [CsrDataWidth-1:0] channels, logic [CsrDataWidth-1:0] filters,
         logic [CsrDataWidth-1:0] kernel, int count, int noise_pct);
      configure(channels, filters, kernel);
      repeat (count) random_word(noise_pct);
   endtask

   initial begin : receiver
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (receiver_hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (receiver_hold) @(posedge clock);
            receiver_hold = 0;
         end else if (receiver_gaps && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= ACT_RESTART;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Every weight entry that the settings below can reach, and every bias entry, is given
      // a value before any frame is computed.
      for (int a = 0; a < WEIGHT_ENTRIES; a++) send_word(ACT_LOAD_WEIGHT, EntryWidth'(a),
         pick_value());
      for (int b = 0; b < BIAS_ENTRIES; b++) send_word(ACT_LOAD_BIAS, EntryWidth'(b),
         pick_value());

      configure(6'd2, 6'd3, 6'd2);
      send_word(ACT_LOAD_WEIGHT, 11'd0, 16'h7fff);
      send_word(ACT_LOAD_WEIGHT, 11'd1, 16'h8000);
      send_word(ACT_LOAD_WEIGHT, 11'd2, 16'h0001);
      send_word(ACT_LOAD_WEIGHT, 11'd5, 16'h0000);
      send_word(ACT_LOAD_WEIGHT, 11'd8, 16'h0000);
      send_word(ACT_LOAD_WEIGHT, 11'd11, 16'h0000);
      send_word(ACT_LOAD_WEIGHT, 11'd2047, 16'h8000);
      send_word(ACT_LOAD_BIAS, 11'd0, 16'h7fff);
      send_word(ACT_LOAD_BIAS, 11'd1, 16'h8000);
      send_word(ACT_LOAD_BIAS, 11'd2, 16'h0000);
      send_word(ACT_LOAD_BIAS, 11'd31, 16'h0080);
      send_word(ACT_LOAD_BIAS, 11'd32, 16'h1234);
      send_word(ACT_LOAD_BIAS, 11'd2047, 16'h7fff);
      send_sample(16'h7fff);
      send_sample(16'h8000);
      // A restart in the middle of a frame throws the partial frame away.
      send_sample(16'h0001);
      send_word(ACT_RESTART, 11'h7ff, 16'hffff);
      send_sample(16'h8000);
      send_sample(16'h8000);
      send_sample(16'h7fff);
      send_sample(16'h7fff);
      // Filter two of the last frame then lands exactly halfway between two output steps.
      send_sample(16'h0080);
      send_sample(16'h0000);
      send_sample(16'h0000);
      send_sample(16'h0000);

      run_phase(6'd1, 6'd1, 6'd1, 15, 10);
      // Zero settings act as the minimum.
      run_phase(6'd0, 6'd0, 6'd0, 20, 0);
      run_phase(6'd31, 6'd2, 6'd1, 20, 5);
      run_phase(6'd1, 6'd63, 6'd7, 15, 4);
      repeat (3) begin
         run_phase(CsrDataWidth'($urandom_range(1, 4)), CsrDataWidth'($urandom_range(1, 6)),
            CsrDataWidth'($urandom_range(1, 4)), 15, 10);
      end
      run_phase(6'd4, 6'd8, 6'd4, 20, 2);

      configure(6'd2, 6'd4, 6'd1);
      receiver_hold = HOLD_CYCLES;
      repeat (20) random_word(5);

      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      run_phase(6'd3, 6'd3, 6'd2, 15, 5);
      wait_drained();

      @(negedge clock);
      if (failures == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_CYCLES * 2 * CLOCK_HALF);
      $display("tb: done, errors");
      $finish;
   end

endmodule
